[hdl/sppd_pkg.sv]
// Shared types, constants and the log2 table for the spectral peak power block.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package sppd_pkg;

	// sample and fixed-point settings
	localparam int SAMPLE_BITS  = 16;
	localparam int DB_FRAC_BITS = 8;

	localparam int MAG_W   = SAMPLE_BITS + 1;  // |x| of a two's complement sample
	localparam int SQ_W    = 2 * MAG_W;
	localparam int POWER_W = 32;
	localparam int EXP_W   = 5;                // leading-one index of a power word
	localparam int TAB_W   = 17;               // table holds up to 65536
	localparam int DIFF_W  = 13;               // largest step between entries is 5732
	localparam int FRAC_W  = 16;
	localparam int LOGQ_W  = EXP_W + FRAC_W;   // log2 in Q16
	localparam int SCALE_W = 26;
	localparam int PROD_W  = LOGQ_W + SCALE_W;
	localparam int DB_W    = 15;

	// 10*log10(2) in Q24
	localparam logic [SCALE_W-1:0] DB_SCALE = SCALE_W'(50504453);
	localparam int DB_SHIFT = 40 - DB_FRAC_BITS;
	localparam logic [PROD_W:0] DB_ROUND = (PROD_W + 1)'(1) << (DB_SHIFT - 1);
	localparam logic [DB_W-1:0] DB_MAX = {DB_W{1'b1}};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] real_part;
		logic signed [SAMPLE_BITS-1:0] imag_part;
		logic                          last_bin;
	} bin_t;

	typedef struct packed {
		logic [POWER_W-1:0] peak_power;
		logic [DB_W-1:0]    peak_db;
		logic               zero_power;
	} peak_t;

	// link between pipeline sections
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [POWER_W-1:0] power;
	} pwr_link_t;

	// round(65536*log2(1+k/16)), k = 0..16
	function automatic logic [TAB_W-1:0] log2_tab(input logic [EXP_W-1:0] k);
		logic [TAB_W-1:0] v;
		case (k)
			5'd0:    v = TAB_W'(0);
			5'd1:    v = TAB_W'(5732);
			5'd2:    v = TAB_W'(11136);
			5'd3:    v = TAB_W'(16248);
			5'd4:    v = TAB_W'(21098);
			5'd5:    v = TAB_W'(25711);
			5'd6:    v = TAB_W'(30109);
			5'd7:    v = TAB_W'(34312);
			5'd8:    v = TAB_W'(38336);
			5'd9:    v = TAB_W'(42196);
			5'd10:   v = TAB_W'(45904);
			5'd11:   v = TAB_W'(49472);
			5'd12:   v = TAB_W'(52911);
			5'd13:   v = TAB_W'(56229);
			5'd14:   v = TAB_W'(59434);
			5'd15:   v = TAB_W'(62534);
			5'd16:   v = TAB_W'(65536);
			default: v = TAB_W'(0);
		endcase
		return v;
	endfunction

endpackage

[hdl/sppd_power.sv]
// Bin power front end: input register, squaring, sum with saturation.
// Depends on sppd_pkg.
`timescale 1ns / 1ps

module sppd_power (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           bin_valid,
	output logic           bin_stall,
	input  sppd_pkg::bin_t bin,
	output sppd_pkg::pwr_link_t pwr,
	input  logic           pwr_ready
);
	import sppd_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	bin_t bin_s1;
	logic [SQ_W-1:0] re_sq_s2, im_sq_s2;
	logic last_s2, last_s3;
	logic [POWER_W-1:0] power_s3;

	logic [MAG_W-1:0] re_mag, im_mag;
	logic [SQ_W:0]    sum;

	assign rdy_s3 = !v_s3 || pwr_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign bin_stall = !rdy_s1;

	function automatic logic [MAG_W-1:0] mag(input logic signed [SAMPLE_BITS-1:0] x);
		logic [MAG_W-1:0] ext;
		ext = {x[SAMPLE_BITS-1], x};
		return x[SAMPLE_BITS-1] ? (MAG_W'(0) - ext) : ext;
	endfunction

	assign re_mag = mag(bin_s1.real_part);
	assign im_mag = mag(bin_s1.imag_part);
	assign sum = {1'b0, re_sq_s2} + {1'b0, im_sq_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= bin_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) bin_s1 <= bin;
		if (rdy_s2) begin
			re_sq_s2 <= re_mag * re_mag;
			im_sq_s2 <= im_mag * im_mag;
			last_s2  <= bin_s1.last_bin;
		end
		if (rdy_s3) begin
			// clamp anything that does not fit the power word
			power_s3 <= (|sum[SQ_W:POWER_W]) ? {POWER_W{1'b1}} : sum[POWER_W-1:0];
			last_s3  <= last_s2;
		end
	end

	assign pwr.valid = v_s3;
	assign pwr.last  = last_s3;
	assign pwr.power = power_s3;

endmodule

[hdl/sppd_peak.sv]
// Running maximum of bin power over one spectrum; releases the peak on the last bin.
// Depends on sppd_pkg.
`timescale 1ns / 1ps

module sppd_peak (
	input  logic                clk,
	input  logic                arst_n,
	input  sppd_pkg::pwr_link_t pwr,
	output logic                pwr_ready,
	output sppd_pkg::pwr_link_t peak,
	input  logic                peak_ready
);
	import sppd_pkg::*;

	logic [POWER_W-1:0] max_q;
	logic [POWER_W-1:0] peak_s4;
	logic [POWER_W-1:0] cand;
	logic v_s4, rdy_s4, take;

	assign rdy_s4 = !v_s4 || peak_ready;
	assign take = pwr.valid && rdy_s4;
	assign cand = (pwr.power > max_q) ? pwr.power : max_q;
	assign pwr_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			v_s4  <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= take && pwr.last;
			if (take) max_q <= pwr.last ? '0 : cand;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pwr.last) peak_s4 <= cand;
	end

	assign peak.valid = v_s4;
	assign peak.last  = 1'b1;
	assign peak.power = peak_s4;

endmodule

[hdl/sppd_db.sv]
// Peak power to decibels: leading one, table interpolation of log2, scaling, rounding.
// Depends on sppd_pkg.
`timescale 1ns / 1ps

module sppd_db (
	input  logic                clk,
	input  logic                arst_n,
	input  sppd_pkg::pwr_link_t peak,
	output logic                peak_ready,
	output logic                res_valid,
	input  logic                res_stall,
	output sppd_pkg::peak_t     res
);
	import sppd_pkg::*;

	logic v_s5, v_s6, v_s7, v_s8, v_s9;
	logic rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;

	logic [POWER_W-1:0] pw_s5, pw_s6, pw_s7, pw_s8, pw_s9;
	logic [EXP_W-1:0]   e_s5, e_s6;
	logic [TAB_W-1:0]   tk_s6;
	logic [DIFF_W-1:0]  dk_s6;
	logic [FRAC_W-1:0]  r_s6;
	logic [LOGQ_W-1:0]  lq_s7;
	logic [PROD_W-1:0]  prod_s8;
	logic [DB_W-1:0]    db_s9;
	logic               zero_s9;

	logic [EXP_W-1:0]   lead;
	logic [POWER_W-1:0] norm;
	logic [3:0]         k;
	logic [EXP_W-1:0]   k0, k1;
	logic [TAB_W-1:0]   t0, t1;
	logic [DIFF_W+FRAC_W-1:0] interp;
	logic [LOGQ_W:0]    lq_sum;
	logic [PROD_W:0]    rounded;
	logic [PROD_W:0]    db_wide;

	assign rdy_s9 = !v_s9 || !res_stall;
	assign rdy_s8 = !v_s8 || rdy_s9;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign peak_ready = rdy_s5;

	// leading one; a zero word gives 0 and is overridden at the end
	always_comb begin
		lead = '0;
		for (int i = 0; i < POWER_W; i++) begin
			if (peak.power[i]) lead = EXP_W'(i);
		end
	end

	assign norm = pw_s5 << (EXP_W'(POWER_W - 1) - e_s5);
	assign k  = norm[30:27];
	assign k0 = {1'b0, k};
	assign k1 = k0 + EXP_W'(1);
	assign t0 = log2_tab(k0);
	assign t1 = log2_tab(k1);

	assign interp = dk_s6 * r_s6;
	assign lq_sum = {1'b0, e_s6, {FRAC_W{1'b0}}} + (LOGQ_W + 1)'(tk_s6)
	              + (LOGQ_W + 1)'(interp[DIFF_W+FRAC_W-1:FRAC_W]);

	assign rounded = {1'b0, prod_s8} + DB_ROUND;
	assign db_wide = rounded >> DB_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= peak.valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
			if (rdy_s9) v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			pw_s5 <= peak.power;
			e_s5  <= lead;
		end
		if (rdy_s6) begin
			pw_s6 <= pw_s5;
			e_s6  <= e_s5;
			tk_s6 <= t0;
			dk_s6 <= DIFF_W'(t1 - t0);
			r_s6  <= norm[26:11];
		end
		if (rdy_s7) begin
			pw_s7 <= pw_s6;
			lq_s7 <= lq_sum[LOGQ_W-1:0];
		end
		if (rdy_s8) begin
			pw_s8   <= pw_s7;
			prod_s8 <= lq_s7 * DB_SCALE;
		end
		if (rdy_s9) begin
			pw_s9   <= pw_s8;
			zero_s9 <= (pw_s8 == '0);
			if (pw_s8 == '0)
				db_s9 <= '0;
			else if (|db_wide[PROD_W:DB_W])
				db_s9 <= DB_MAX;
			else
				db_s9 <= db_wide[DB_W-1:0];
		end
	end

	assign res_valid      = v_s9;
	assign res.peak_power = pw_s9;
	assign res.peak_db    = db_s9;
	assign res.zero_power = zero_s9;

endmodule

[hdl/spectral_peak_power_db.sv]
// Spectral peak power in decibels, top level.
// Depends on sppd_pkg, sppd_power, sppd_peak and sppd_db.
`timescale 1ns / 1ps

// Accepts one complex FFT bin per clock while bin_stall is low (real_part,
// imag_part, last_bin) and keeps the largest real^2 + imag^2 seen in the
// current spectrum. The transfer carrying last_bin closes the spectrum: that
// bin is included, and one result follows with the peak raw power, the peak as
// 10*log10 in 1/256 dB steps and a flag for an all-zero spectrum (dB then
// reads 0). The running maximum is then cleared; bins without last_bin produce
// no result. Throughput is one bin per clock while bin_stall is low, set by
// the compare that feeds the running-maximum register. There are nine
// register stages, the first being the input register and the last the
// output register. Every stage can hold an item, so bins keep flowing while
// a result waits on peak_stall; the input stalls only once all stages behind
// a stalled result are occupied.
module spectral_peak_power_db (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            bin_valid,
	output logic            bin_stall,
	input  sppd_pkg::bin_t  bin,
	output logic            peak_valid,
	input  logic            peak_stall,
	output sppd_pkg::peak_t peak
);
	import sppd_pkg::*;

	pwr_link_t pwr;       // per-bin power, three stages in
	pwr_link_t spec_peak; // closed-spectrum peak from the running maximum
	logic      pwr_ready;
	logic      peak_ready;

	// input register, squares, saturating sum
	sppd_power u_power (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin       (bin),
		.pwr       (pwr),
		.pwr_ready (pwr_ready)
	);

	// running maximum, cleared on the last bin
	sppd_peak u_peak (
		.clk        (clk),
		.arst_n     (arst_n),
		.pwr        (pwr),
		.pwr_ready  (pwr_ready),
		.peak       (spec_peak),
		.peak_ready (peak_ready)
	);

	// log2 by table interpolation, scaled to dB, rounded; final stage is the
	// output register
	sppd_db u_db (
		.clk        (clk),
		.arst_n     (arst_n),
		.peak       (spec_peak),
		.peak_ready (peak_ready),
		.res_valid  (peak_valid),
		.res_stall  (peak_stall),
		.res        (peak)
	);

`ifndef SYNTHESIS
	// an empty output stage never holds back the input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!peak_valid |-> !bin_stall)
		else $error("input stalled with no result pending");

	// zero flag tracks the raw peak
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		peak_valid |-> (peak.zero_power == (peak.peak_power == '0)))
		else $error("zero_power disagrees with peak_power");

	// zero peak reports 0 dB
	a_zero_db: assert property (@(posedge clk) disable iff (!arst_n)
		(peak_valid && peak.zero_power) |-> (peak.peak_db == '0))
		else $error("nonzero dB on a zero peak");

	// unit power is the bottom of the dB scale, 0 dB
	a_db_range: assert property (@(posedge clk) disable iff (!arst_n)
		(peak_valid && (peak.peak_power == 32'd1)) |-> (peak.peak_db == '0))
		else $error("unit power must map to 0 dB");
`endif

endmodule

[dv/spectral_peak_power_db_test.sv]
// Self-checking testbench for spectral_peak_power_db: bins in, one peak result per spectrum.
// Depends on sppd_pkg and the RTL in hdl/; needs no files or arguments at run time.
`timescale 1ns / 1ps

module spectral_peak_power_db_test;

	import sppd_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 20;       // extra wait after the results drain, with headroom
	localparam longint unsigned TEN_LOG10_2_Q24 = 64'd50504453;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   bin_valid;
	logic   bin_stall;
	bin_t   bin;
	logic   peak_valid;
	logic   peak_stall;
	peak_t  peak;

	spectral_peak_power_db dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.bin_valid  (bin_valid),
		.bin_stall  (bin_stall),
		.bin        (bin),
		.peak_valid (peak_valid),
		.peak_stall (peak_stall),
		.peak       (peak)
	);

	always #5 clk = ~clk;

	// log2(1+k/16) in Q16, segment ends for the interpolation
	longint unsigned log2_steps [0:16] = '{
		0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
		42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
	};

	// predictor state
	logic [POWER_W-1:0] spectrum_max;
	peak_t              expected_peaks [$];

	// run statistics and error tally
	int error_count;
	int bins_sent;
	int spectra_sent;
	int results_checked;
	int input_stall_cycles;
	int longest_input_stall;
	int stall_run_now;
	int cycle_count;

	// idling controls shared with the stall process
	bit gaps_enable;
	bit stall_enable;
	int hold_request;

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// power of one bin; saturates to all ones (cannot happen at 16-bit samples)
	function automatic logic [POWER_W-1:0] bin_power(bin_t b);
		longint re;
		longint im;
		longint unsigned sum;
		re = longint'(b.real_part);
		im = longint'(b.imag_part);
		if (re < 0) re = -re;
		if (im < 0) im = -im;
		sum = re * re + im * im;
		if (sum > 64'hFFFF_FFFF)
			return '1;
		return sum[POWER_W-1:0];
	endfunction

	// 10*log10(p) in 1/2^DB_FRAC_BITS dB, via a 16-segment log2 interpolation
	function automatic logic [DB_W-1:0] power_to_db(logic [POWER_W-1:0] p);
		int lead;
		logic [31:0] norm;
		int seg;
		longint unsigned frac;
		longint unsigned log_q16;
		longint unsigned scaled;
		longint unsigned db;
		lead = 31;
		while (lead > 0 && !p[lead])
			lead--;
		norm = p << (31 - lead);
		seg  = int'(norm[30:27]);
		frac = 64'(norm[26:11]);
		log_q16 = (longint'(lead) << 16) + log2_steps[seg]
			+ (((log2_steps[seg + 1] - log2_steps[seg]) * frac) >> 16);
		scaled = log_q16 * TEN_LOG10_2_Q24;
		db = (scaled + (64'd1 << (39 - DB_FRAC_BITS))) >> (40 - DB_FRAC_BITS);
		if (db > 32767)
			db = 32767;
		return db[DB_W-1:0];
	endfunction

	// fold one accepted bin into the running maximum; a last bin closes the spectrum
	task automatic fold_bin(bin_t b);
		logic [POWER_W-1:0] p;
		logic [POWER_W-1:0] top;
		peak_t              res;
		p   = bin_power(b);
		top = (p > spectrum_max) ? p : spectrum_max;
		if (!b.last_bin) begin
			spectrum_max = top;
		end else begin
			res.peak_power = top;
			res.zero_power = (top == '0);
			res.peak_db    = (top == '0) ? '0 : power_to_db(top);
			expected_peaks = {expected_peaks, res};
			spectrum_max = '0;
			spectra_sent++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// mostly back to back, some short gaps, the odd long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sample drawn from full range, small values, scaled values and extremes
	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		logic signed [SAMPLE_BITS-1:0] s;
		case ($urandom_range(0, 3))
			0: s = SAMPLE_BITS'($urandom);
			1: begin
				s = SAMPLE_BITS'($urandom_range(0, 15));
				if ($urandom_range(0, 1)) s = -s;
			end
			2: begin
				s = SAMPLE_BITS'($urandom);
				s = s >>> $urandom_range(0, SAMPLE_BITS - 1);
			end
			default: begin
				case ($urandom_range(0, 4))
					0: s = 16'sh8000;
					1: s = 16'sh7FFF;
					2: s = 16'sh0000;
					3: s = -16'sd1;
					default: s = 16'sd1;
				endcase
			end
		endcase
		return s;
	endfunction

	// offer one bin after an optional gap, hold it until the transfer
	task automatic send_bin(logic signed [SAMPLE_BITS-1:0] re,
	                        logic signed [SAMPLE_BITS-1:0] im, logic last);
		bin_t b;
		int   gap;
		b.real_part = re;
		b.imag_part = im;
		b.last_bin  = last;
		gap = gaps_enable ? idle_length() : 0;
		repeat (gap) begin
			@(negedge clk);
			bin_valid <= 1'b0;
		end
		@(negedge clk);
		bin       <= b;
		bin_valid <= 1'b1;
		do
			@(posedge clk);
		while (bin_stall);
		fold_bin(b);
		bins_sent++;
	endtask

	// one spectrum of random bins; the last one carries last_bin
	task automatic send_spectrum(int len);
		for (int i = 0; i < len; i++)
			send_bin(random_sample(), random_sample(), i == len - 1);
	endtask

	// sender goes quiet until every predicted result has been seen
	task automatic wait_results_drained();
		@(negedge clk);
		bin_valid <= 1'b0;
		while (expected_peaks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic report_mismatch(string what, longint unsigned got,
	                               longint unsigned want);
		$display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		peak_t want;
		if (arst_n) begin
			if (bin_valid && bin_stall) begin
				input_stall_cycles++;
				stall_run_now++;
				if (stall_run_now > longest_input_stall)
					longest_input_stall = stall_run_now;
			end else begin
				stall_run_now = 0;
			end
			if (peak_valid && !peak_stall) begin
				if (expected_peaks.size() == 0) begin
					report_mismatch("result with none pending, peak_power",
						peak.peak_power, 0);
				end else begin
					want = expected_peaks.pop_front();
					if (peak.peak_power !== want.peak_power)
						report_mismatch("peak_power", peak.peak_power, want.peak_power);
					if (peak.peak_db !== want.peak_db)
						report_mismatch("peak_db", peak.peak_db, want.peak_db);
					if (peak.zero_power !== want.zero_power)
						report_mismatch("zero_power", peak.zero_power, want.zero_power);
					results_checked++;
				end
			end
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin : drive_peak_stall
		int hold_left;
		int stall_left;
		hold_left  = 0;
		stall_left = 0;
		peak_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				peak_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				peak_stall <= 1'b1;
			end else if (stall_enable && $urandom_range(0, 99) < 25) begin
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
				                                       : $urandom_range(20, 60);
				peak_stall <= 1'b1;
			end else begin
				peak_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycle_count, expected_peaks.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// field extremes, zero spectra, single-bin spectra, bin order within a spectrum
	task automatic test_directed_bins();
		send_bin(16'sd0, 16'sd0, 1'b1);               // zero peak, dB forced to 0
		send_bin(16'sh8000, 16'sh8000, 1'b1);         // largest power, 2^31
		send_bin(16'sh7FFF, 16'sh7FFF, 1'b1);
		send_bin(16'sh8000, 16'sd0, 1'b1);            // exact power of two
		send_bin(16'sd1, 16'sd0, 1'b1);               // power 1, 0 dB but not zero
		send_bin(16'sd0, -16'sd1, 1'b1);
		send_bin(16'sh5555, 16'shAAAA, 1'b1);         // alternating bit patterns
		send_bin(16'shAAAA, 16'sh5555, 1'b1);
		send_bin(16'sd255, -16'sd256, 1'b1);
		// peak early, smaller bins after it
		send_bin(-16'sd100, 16'sd50, 1'b0);
		send_bin(16'sd3, 16'sd4, 1'b0);
		send_bin(16'sd0, 16'sd0, 1'b0);
		send_bin(16'sd7, -16'sd7, 1'b1);
		// peak on the last bin itself
		send_bin(16'sd1, 16'sd1, 1'b0);
		send_bin(16'sd2, 16'sd2, 1'b0);
		send_bin(16'sh8000, 16'sh7FFF, 1'b1);
		// all-zero spectrum of several bins
		send_bin(16'sd0, 16'sd0, 1'b0);
		send_bin(16'sd0, 16'sd0, 1'b0);
		send_bin(16'sd0, 16'sd0, 1'b1);
		// maximum is cleared: a small spectrum after a large one
		send_bin(16'sh7FFF, 16'sh8000, 1'b0);
		send_bin(16'sd1, 16'sd0, 1'b1);
		send_bin(16'sd0, 16'sd3, 1'b1);
		wait_results_drained();
	endtask

	// random spectra, mostly short, with idling on both sides
	task automatic test_random_spectra(int bin_budget);
		int start;
		start = bins_sent;
		while (bins_sent - start < bin_budget) begin
			if ($urandom_range(0, 9) < 8)
				send_spectrum($urandom_range(1, 12));
			else
				send_spectrum($urandom_range(13, 48));
		end
	endtask

	// result side blocked for a long stretch while bins keep coming, so the
	// stages fill and the input backs up; last bins are dense on purpose
	task automatic test_output_hold_off();
		gaps_enable  = 1'b0;
		stall_enable = 1'b0;
		hold_request = 300;
		for (int i = 0; i < 160; i++)
			send_bin(random_sample(), random_sample(), $urandom_range(0, 2) == 0);
		wait_results_drained();
		gaps_enable  = 1'b1;
		stall_enable = 1'b1;
	endtask

	// sender pauses for a full drain between spectra; some stretches with no idling
	task automatic test_drain_between_spectra();
		for (int n = 0; n < 8; n++) begin
			gaps_enable  = n[0];
			stall_enable = n[1];
			send_spectrum($urandom_range(1, 10));
			wait_results_drained();
		end
		gaps_enable  = 1'b1;
		stall_enable = 1'b1;
	endtask

	initial begin
		arst_n       = 1'b0;
		bin_valid    = 1'b0;
		bin          = '0;
		spectrum_max = '0;
		gaps_enable  = 1'b1;
		stall_enable = 1'b1;
		hold_request = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_bins();
		test_random_spectra(500);
		test_output_hold_off();
		test_drain_between_spectra();
		test_random_spectra(500);

		wait_results_drained();

		$display("Sent %0d bins in %0d spectra, checked %0d results in %0d cycles.",
			bins_sent, spectra_sent, results_checked, cycle_count);
		$display("Input held back for %0d cycles, longest run %0d; mismatches: %0d.",
			input_stall_cycles, longest_input_stall, error_count);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[files.f]
hdl/sppd_pkg.sv
hdl/sppd_power.sv
hdl/sppd_peak.sv
hdl/sppd_db.sv
hdl/spectral_peak_power_db.sv
dv/spectral_peak_power_db_test.sv
